@@ rtl/core/plk_pkg.sv @@
// Shared types, constants and saturation helpers for the plucked-string voice.
// Used by plk_div, plk_mac and the voice top level in rtl/core; depends on nothing else.
package plk_pkg;

  // Delay line geometry
  localparam int MAX_DELAY = 65536;
  localparam int ADDR_W    = $clog2(MAX_DELAY);
  localparam int LEN_W     = ADDR_W + 1;

  // Field widths
  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 16;
  localparam int RATE_W       = 18;
  localparam int PITCH_W      = 20;
  localparam int PITCH_FRAC_W = 4;
  localparam int LP_W         = 18;
  localparam int Y_W          = SAMPLE_W + 4;

  localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(48000);
  localparam logic [PITCH_W-1:0] PITCH_MIN  = PITCH_W'(1 << PITCH_FRAC_W);
  localparam logic [COEF_W:0]    COEF_ONE   = (COEF_W + 1)'(1 << (COEF_W - 1));

  // Divider operands: rate in 1/16 Hz over pitch, or position over length
  localparam int DIV_NUM_W = RATE_W + PITCH_FRAC_W;
  localparam int DIV_DEN_W = PITCH_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Multiply-accumulate unit
  localparam int MAC_A_W = 32;
  localparam int MAC_B_W = 19;
  localparam int MAC_W   = 52;

  localparam int LP_SHIFT = 28;
  localparam int AP_SHIFT = 15;
  localparam logic signed [MAC_W-1:0] LP_HALF = MAC_W'(1) <<< (LP_SHIFT - 1);
  localparam logic signed [MAC_W-1:0] AP_HALF = MAC_W'(1) <<< (AP_SHIFT - 1);

  localparam int Q17_MAX = (1 << (LP_W - 1)) - 1;
  localparam int Q15_MAX = (1 << (SAMPLE_W - 1)) - 1;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic                       en;
    logic signed [MAC_A_W-1:0]  a;
    logic signed [MAC_B_W-1:0]  b;
    logic signed [MAC_W-1:0]    addend;
  } mac_req_t;

  function automatic logic signed [LP_W-1:0] sat_q17(input logic signed [MAC_W-1:0] x);
    logic signed [MAC_W-1:0] hi;
    logic signed [MAC_W-1:0] lo;
    hi = MAC_W'(Q17_MAX);
    lo = -hi - MAC_W'(1);
    if (x > hi) begin
      return LP_W'(hi);
    end else if (x < lo) begin
      return LP_W'(lo);
    end
    return LP_W'(x);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_q15(input logic signed [Y_W-1:0] x);
    logic signed [Y_W-1:0] hi;
    logic signed [Y_W-1:0] lo;
    hi = Y_W'(Q15_MAX);
    lo = -hi - Y_W'(1);
    if (x > hi) begin
      return SAMPLE_W'(hi);
    end else if (x < lo) begin
      return SAMPLE_W'(lo);
    end
    return SAMPLE_W'(x);
  endfunction

endpackage

@@ rtl/core/plk_ram.sv @@
// Generic single-port RAM with a registered read, one access per cycle.
// Self-contained; sized by its WIDTH and DEPTH parameters.
module plk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/core/plk_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on plk_pkg for operand widths and the request/response structs.
module plk_div (
  input  logic               clk,
  input  logic               rst_n,
  input  plk_pkg::div_req_t  req,
  output plk_pkg::div_rsp_t  rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [plk_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [plk_pkg::DIV_NUM_W-1:0] num_r, num_nxt;
  logic [plk_pkg::DIV_DEN_W-1:0] den_r, den_nxt;
  logic [plk_pkg::DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [plk_pkg::DIV_DEN_W+1:0] trial;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    trial    = {1'b0, rem_r, num_r[plk_pkg::DIV_NUM_W-1]} - {2'b00, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = plk_pkg::DIV_CNT_W'(plk_pkg::DIV_NUM_W);
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (!trial[plk_pkg::DIV_DEN_W+1]) begin
        rem_nxt = trial[plk_pkg::DIV_DEN_W-1:0];
        num_nxt = {num_r[plk_pkg::DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[plk_pkg::DIV_DEN_W-2:0], num_r[plk_pkg::DIV_NUM_W-1]};
        num_nxt = {num_r[plk_pkg::DIV_NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - plk_pkg::DIV_CNT_W'(1);
      if (cnt_r == plk_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = num_r;
  assign rsp.rem  = rem_r;

endmodule

@@ rtl/core/plk_mac.sv @@
// Shared signed multiply-add with a registered result, used for all filter products.
// Depends on plk_pkg for operand widths and the request struct.
module plk_mac (
  input  logic                               clk,
  input  plk_pkg::mac_req_t                  req,
  output logic signed [plk_pkg::MAC_W-1:0]   acc
);

  logic signed [plk_pkg::MAC_A_W+plk_pkg::MAC_B_W-1:0] prod;
  logic signed [plk_pkg::MAC_W-1:0]                    acc_r, acc_nxt;

  assign prod    = req.a * req.b;
  assign acc_nxt = plk_pkg::MAC_W'(prod) + req.addend;

  always_ff @(posedge clk) begin
    if (req.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

@@ rtl/core/plucked_string_synth_voice.sv @@
// Plucked-string voice top level: sequencer, delay memory, divider and multiply-add unit.
// Input is stalled from an accepted word until its result word has entered the output register.
// Each word waits on the 22-step divider that turns rate over pitch into the delay length.
// When the delay length drops to half the position or less, a second division yields the position.
// Synchronous reset starts a pass that clears all 65536 delay memory words; no word is taken meanwhile.
module plucked_string_synth_voice (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [plk_pkg::SAMPLE_W-1:0]   in_pluck_sample,
  input  logic        [plk_pkg::PITCH_W-1:0]    in_pitch_q4,
  input  logic        [plk_pkg::COEF_W-1:0]     in_stretch_coeff,
  input  logic        [plk_pkg::COEF_W-1:0]     in_loss_coeff,
  input  logic signed [plk_pkg::COEF_W-1:0]     in_tune_coeff,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [plk_pkg::SAMPLE_W-1:0]   out_string_sample,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [plk_pkg::RATE_W-1:0]     cfg_sample_rate
);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_DIVL = 4'd2;
  localparam logic [3:0] ST_POS  = 4'd3;
  localparam logic [3:0] ST_DIVP = 4'd4;
  localparam logic [3:0] ST_RD   = 4'd5;
  localparam logic [3:0] ST_MAC1 = 4'd6;
  localparam logic [3:0] ST_MAC2 = 4'd7;
  localparam logic [3:0] ST_LP   = 4'd8;
  localparam logic [3:0] ST_MAC3 = 4'd9;
  localparam logic [3:0] ST_AP   = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  logic [3:0]                          state_r, state_nxt;
  logic [plk_pkg::ADDR_W-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [plk_pkg::RATE_W-1:0]          rate_r, rate_nxt;
  logic [plk_pkg::LEN_W-1:0]           rw_r, rw_nxt;
  logic [plk_pkg::LEN_W-1:0]           len_r, len_nxt;
  logic [plk_pkg::ADDR_W-1:0]          pos_r, pos_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [plk_pkg::SAMPLE_W-1:0] out_sample_r, out_sample_nxt;

  logic signed [plk_pkg::SAMPLE_W-1:0] pluck_r, pluck_nxt;
  logic        [plk_pkg::COEF_W:0]     s_r, s_nxt;
  logic        [plk_pkg::COEF_W:0]     p_r, p_nxt;
  logic signed [plk_pkg::COEF_W-1:0]   c_r, c_nxt;
  logic signed [plk_pkg::SAMPLE_W-1:0] tap_r, tap_nxt;
  logic signed [plk_pkg::SAMPLE_W-1:0] prev_tap_r, prev_tap_nxt;
  logic signed [plk_pkg::LP_W-1:0]     prev_lp_r, prev_lp_nxt;
  logic signed [plk_pkg::LP_W-1:0]     prev_ap_r, prev_ap_nxt;
  logic signed [plk_pkg::LP_W-1:0]     lp_r, lp_nxt;
  logic signed [plk_pkg::LP_W-1:0]     ap_r, ap_nxt;

  logic                                accept;
  logic                                out_free;
  logic [plk_pkg::PITCH_W-1:0]         pitch_clamped;
  logic [plk_pkg::LEN_W-1:0]           rw_minus_len;
  logic signed [plk_pkg::SAMPLE_W:0]   tap_diff;
  logic signed [plk_pkg::Y_W-1:0]      y_sum;
  logic signed [plk_pkg::SAMPLE_W-1:0] y_sat;

  logic                                ram_we;
  logic [plk_pkg::ADDR_W-1:0]          ram_addr;
  logic [plk_pkg::SAMPLE_W-1:0]        ram_wdata;
  logic [plk_pkg::SAMPLE_W-1:0]        ram_rdata;

  plk_pkg::div_req_t                   div_req;
  plk_pkg::div_rsp_t                   div_rsp;
  plk_pkg::mac_req_t                   mac_req;
  logic signed [plk_pkg::MAC_W-1:0]    mac_acc;

  plk_ram #(
    .WIDTH (plk_pkg::SAMPLE_W),
    .DEPTH (plk_pkg::MAX_DELAY)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  plk_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  plk_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .acc (mac_acc)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_string_sample = out_sample_r;

  assign pitch_clamped = (in_pitch_q4 < plk_pkg::PITCH_MIN) ? plk_pkg::PITCH_MIN : in_pitch_q4;
  assign rw_minus_len  = rw_r - len_r;
  assign tap_diff      = {ram_rdata[plk_pkg::SAMPLE_W-1], ram_rdata}
                       - {prev_tap_r[plk_pkg::SAMPLE_W-1], prev_tap_r};

  // Excitation is brought to Q1.17, added, and rounded back to Q1.15 with ties upward.
  assign y_sum = (plk_pkg::Y_W'(pluck_r) <<< 2) + plk_pkg::Y_W'(ap_r) + plk_pkg::Y_W'(2);
  assign y_sat = plk_pkg::sat_q15(y_sum >>> 2);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pos_r;
    ram_wdata = y_sat;
    if (state_r == ST_CLR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_r;
      ram_wdata = '0;
    end else if (state_r == ST_OUT && out_free) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    rate_nxt       = rate_r;
    rw_nxt         = rw_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;
    pluck_nxt      = pluck_r;
    s_nxt          = s_r;
    p_nxt          = p_r;
    c_nxt          = c_r;
    tap_nxt        = tap_r;
    prev_tap_nxt   = prev_tap_r;
    prev_lp_nxt    = prev_lp_r;
    prev_ap_nxt    = prev_ap_r;
    lp_nxt         = lp_r;
    ap_nxt         = ap_r;

    div_req.start  = 1'b0;
    div_req.num    = {rate_r, {plk_pkg::PITCH_FRAC_W{1'b0}}};
    div_req.den    = pitch_clamped;

    mac_req.en     = 1'b0;
    mac_req.a      = plk_pkg::MAC_A_W'(signed'({1'b0, s_r}));
    mac_req.b      = plk_pkg::MAC_B_W'(tap_diff);
    mac_req.addend = plk_pkg::MAC_W'(prev_tap_r) <<< 15;

    if (cfg_valid && cfg_ready) begin
      rate_nxt = cfg_sample_rate;
    end

    case (state_r)
      ST_CLR: begin
        clr_cnt_nxt = clr_cnt_r + plk_pkg::ADDR_W'(1);
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          div_req.start = 1'b1;
          pluck_nxt = in_pluck_sample;
          s_nxt = ({1'b0, in_stretch_coeff} > plk_pkg::COEF_ONE) ?
                  plk_pkg::COEF_ONE : {1'b0, in_stretch_coeff};
          p_nxt = ({1'b0, in_loss_coeff} > plk_pkg::COEF_ONE) ?
                  plk_pkg::COEF_ONE : {1'b0, in_loss_coeff};
          c_nxt = in_tune_coeff;
          state_nxt = ST_DIVL;
        end
      end
      ST_DIVL: begin
        if (div_rsp.done) begin
          if (div_rsp.quo == '0) begin
            len_nxt = plk_pkg::LEN_W'(1);
          end else if (div_rsp.quo > plk_pkg::DIV_NUM_W'(plk_pkg::MAX_DELAY)) begin
            len_nxt = plk_pkg::LEN_W'(plk_pkg::MAX_DELAY);
          end else begin
            len_nxt = div_rsp.quo[plk_pkg::LEN_W-1:0];
          end
          state_nxt = ST_POS;
        end
      end
      ST_POS: begin
        // Usually the position is below the length or one length above it;
        // only a sharp drop in length needs a full remainder.
        if (rw_r < len_r) begin
          pos_nxt   = rw_r[plk_pkg::ADDR_W-1:0];
          state_nxt = ST_RD;
        end else if (rw_minus_len < len_r) begin
          pos_nxt   = rw_minus_len[plk_pkg::ADDR_W-1:0];
          state_nxt = ST_RD;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = plk_pkg::DIV_NUM_W'(rw_r);
          div_req.den   = plk_pkg::DIV_DEN_W'(len_r);
          state_nxt     = ST_DIVP;
        end
      end
      ST_DIVP: begin
        if (div_rsp.done) begin
          pos_nxt   = div_rsp.rem[plk_pkg::ADDR_W-1:0];
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_MAC1;
      end
      ST_MAC1: begin
        // Stretched lowpass written as prev*2^15 + s*(tap - prev).
        tap_nxt    = signed'(ram_rdata);
        mac_req.en = 1'b1;
        state_nxt  = ST_MAC2;
      end
      ST_MAC2: begin
        mac_req.en     = 1'b1;
        mac_req.a      = signed'(mac_acc[plk_pkg::MAC_A_W-1:0]);
        mac_req.b      = plk_pkg::MAC_B_W'(signed'({1'b0, p_r}));
        mac_req.addend = plk_pkg::LP_HALF;
        state_nxt      = ST_LP;
      end
      ST_LP: begin
        lp_nxt    = plk_pkg::sat_q17(mac_acc >>> plk_pkg::LP_SHIFT);
        state_nxt = ST_MAC3;
      end
      ST_MAC3: begin
        // Allpass written as prev_lp*2^15 + c*(prev_ap - lp).
        mac_req.en     = 1'b1;
        mac_req.a      = plk_pkg::MAC_A_W'(c_r);
        mac_req.b      = plk_pkg::MAC_B_W'(prev_ap_r) - plk_pkg::MAC_B_W'(lp_r);
        mac_req.addend = (plk_pkg::MAC_W'(prev_lp_r) <<< plk_pkg::AP_SHIFT) + plk_pkg::AP_HALF;
        state_nxt      = ST_AP;
      end
      ST_AP: begin
        ap_nxt    = plk_pkg::sat_q17(mac_acc >>> plk_pkg::AP_SHIFT);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = y_sat;
          prev_tap_nxt   = tap_r;
          prev_lp_nxt    = lp_r;
          prev_ap_nxt    = ap_r;
          rw_nxt         = plk_pkg::LEN_W'(pos_r) + plk_pkg::LEN_W'(1);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      rate_r      <= plk_pkg::RATE_RESET;
      rw_r        <= '0;
      len_r       <= plk_pkg::LEN_W'(1);
      out_valid_r <= 1'b0;
      prev_tap_r  <= '0;
      prev_lp_r   <= '0;
      prev_ap_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rate_r      <= rate_nxt;
      rw_r        <= rw_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      prev_tap_r  <= prev_tap_nxt;
      prev_lp_r   <= prev_lp_nxt;
      prev_ap_r   <= prev_ap_nxt;
    end
    pos_r        <= pos_nxt;
    out_sample_r <= out_sample_nxt;
    pluck_r      <= pluck_nxt;
    s_r          <= s_nxt;
    p_r          <= p_nxt;
    c_r          <= c_nxt;
    tap_r        <= tap_nxt;
    lp_r         <= lp_nxt;
    ap_r         <= ap_nxt;
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |-> plk_pkg::LEN_W'(pos_r) < len_r)
    else $error("delay read position not below delay length");

  a_len_limits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POS |-> len_r != '0 && len_r <= plk_pkg::LEN_W'(plk_pkg::MAX_DELAY))
    else $error("delay length outside its limits");

  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVL || state_r == ST_DIVP) |-> div_rsp.busy || div_rsp.done)
    else $error("sequencer waits on an idle divider");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_OUT)
    else $error("result word raised outside the output step");

endmodule

@@ tb/tb_plucked_string_synth_voice.sv @@
// Self-checking testbench for the plucked-string voice: directed extremes, then random notes.
// Predicts every output word from its own model of the string loop; needs only rtl/core.
// Depends on plk_pkg for the field widths, the delay memory size and the reset sample rate.
module tb_plucked_string_synth_voice;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES   = 64;
  localparam longint      Q15_ONE        = 32768;

  localparam logic [plk_pkg::PITCH_W-1:0]         PITCH_TOP = '1;
  localparam logic [plk_pkg::COEF_W-1:0]          COEF_UNIT = 16'h8000;
  localparam logic [plk_pkg::COEF_W-1:0]          COEF_TOP  = '1;
  localparam logic signed [plk_pkg::SAMPLE_W-1:0] PEAK_POS  = 16'sh7FFF;
  localparam logic signed [plk_pkg::SAMPLE_W-1:0] PEAK_NEG  = 16'sh8000;
  localparam logic [plk_pkg::RATE_W-1:0]          RATE_TOP  = '1;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [plk_pkg::SAMPLE_W-1:0] in_pluck_sample = '0;
  logic        [plk_pkg::PITCH_W-1:0]  in_pitch_q4 = '0;
  logic        [plk_pkg::COEF_W-1:0]   in_stretch_coeff = '0;
  logic        [plk_pkg::COEF_W-1:0]   in_loss_coeff = '0;
  logic signed [plk_pkg::COEF_W-1:0]   in_tune_coeff = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b1;
  logic signed [plk_pkg::SAMPLE_W-1:0] out_string_sample;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic        [plk_pkg::RATE_W-1:0]   cfg_sample_rate = '0;

  // String loop state as this testbench sees it
  logic signed [plk_pkg::SAMPLE_W-1:0] delay_line [plk_pkg::MAX_DELAY];
  int unsigned                         rw_pos;
  longint                              last_tap;
  longint                              last_lp;
  longint                              last_ap;
  int unsigned                         rate_hz;

  logic signed [plk_pkg::SAMPLE_W-1:0] pending_samples [$];
  int unsigned                         error_count = 0;
  int unsigned                         quiet_cycles = 0;
  bit                                  feed_steady = 1'b0;
  bit                                  sink_steady = 1'b0;

  plucked_string_synth_voice dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pluck_sample   (in_pluck_sample),
    .in_pitch_q4       (in_pitch_q4),
    .in_stretch_coeff  (in_stretch_coeff),
    .in_loss_coeff     (in_loss_coeff),
    .in_tune_coeff     (in_tune_coeff),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_string_sample (out_string_sample),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_sample_rate   (cfg_sample_rate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Adding one half before an arithmetic shift rounds ties upward.
  function automatic longint round_shift(input longint value, input int unsigned shift);
    return (value + (longint'(1) <<< (shift - 1))) >>> shift;
  endfunction

  function automatic longint clip_signed(input longint value, input int unsigned bits);
    longint top;
    top = (longint'(1) <<< (bits - 1)) - 1;
    if (value > top) begin
      return top;
    end else if (value < -top - 1) begin
      return -top - 1;
    end
    return value;
  endfunction

  function automatic logic signed [plk_pkg::SAMPLE_W-1:0] predict_string_sample(
    input logic signed [plk_pkg::SAMPLE_W-1:0] pluck,
    input logic        [plk_pkg::PITCH_W-1:0]  pitch,
    input logic        [plk_pkg::COEF_W-1:0]   stretch,
    input logic        [plk_pkg::COEF_W-1:0]   loss,
    input logic signed [plk_pkg::COEF_W-1:0]   tune
  );
    int unsigned                pitch_eff;
    int unsigned                loop_len;
    logic [plk_pkg::ADDR_W-1:0] pos;
    longint                     s;
    longint                     g;
    longint                     c;
    longint                     tap;
    longint                     lp;
    longint                     ap;
    longint                     y;
    pitch_eff = 32'((pitch < plk_pkg::PITCH_MIN) ? plk_pkg::PITCH_MIN : pitch);
    s = (stretch > COEF_UNIT) ? Q15_ONE : longint'(stretch);
    g = (loss > COEF_UNIT) ? Q15_ONE : longint'(loss);
    c = longint'(tune);
    loop_len = (rate_hz * 16) / pitch_eff;
    if (loop_len < 1) begin
      loop_len = 1;
    end
    if (loop_len > plk_pkg::MAX_DELAY) begin
      loop_len = plk_pkg::MAX_DELAY;
    end
    // The position may lie beyond a length that has just shrunk.
    pos = plk_pkg::ADDR_W'(rw_pos % loop_len);
    tap = longint'(delay_line[pos]);
    lp = clip_signed(round_shift((s * tap + (Q15_ONE - s) * last_tap) * g, plk_pkg::LP_SHIFT),
                     plk_pkg::LP_W);
    ap = clip_signed(round_shift(-c * lp + last_lp * Q15_ONE + c * last_ap, plk_pkg::AP_SHIFT),
                     plk_pkg::LP_W);
    y = clip_signed(round_shift(longint'(pluck) * 4 + ap, 2), plk_pkg::SAMPLE_W);
    delay_line[pos] = plk_pkg::SAMPLE_W'(y);
    last_tap = tap;
    last_lp = lp;
    last_ap = ap;
    rw_pos = 32'(pos) + 1;
    return plk_pkg::SAMPLE_W'(y);
  endfunction

  task automatic reset_string_model();
    foreach (delay_line[i]) begin
      delay_line[i] = '0;
    end
    rw_pos = 0;
    last_tap = 0;
    last_lp = 0;
    last_ap = 0;
    rate_hz = 32'(plk_pkg::RATE_RESET);
  endtask

  // Mostly back-to-back, sometimes a short gap, now and then a long pause.
  function automatic int unsigned idle_length();
    int unsigned choice;
    choice = $urandom_range(0, 99);
    if (choice < 65) begin
      return 0;
    end else if (choice < 93) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(15, 70);
  endfunction

  // Prediction and checking both work from what is seen on the ports at the clock edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        rate_hz = 32'(cfg_sample_rate);
      end
      if (in_valid && !in_stall) begin
        pending_samples.push_back(predict_string_sample(in_pluck_sample, in_pitch_q4,
                                  in_stretch_coeff, in_loss_coeff, in_tune_coeff));
      end
      if (out_valid && !out_stall) begin
        if (pending_samples.size() == 0) begin
          $display("%0t: string_sample word with none expected, actual %0d",
                   $time, out_string_sample);
          error_count++;
        end else if (out_string_sample !== pending_samples[0]) begin
          $display("%0t: string_sample mismatch, expected %0d, actual %0d",
                   $time, pending_samples[0], out_string_sample);
          error_count++;
          void'(pending_samples.pop_front());
        end else begin
          void'(pending_samples.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side back-pressure.
  initial begin
    int unsigned choice;
    forever begin
      if (sink_steady) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        choice = $urandom_range(0, 99);
        if (choice < 50) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 40)) @(posedge clk);
        end else if (choice < 90) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(20, 80)) @(posedge clk);
        end
      end
    end
  end

  // Leaves in_valid high on return so that the next word can follow without a gap.
  task automatic send_sample(
    input logic signed [plk_pkg::SAMPLE_W-1:0] pluck,
    input logic        [plk_pkg::PITCH_W-1:0]  pitch,
    input logic        [plk_pkg::COEF_W-1:0]   stretch,
    input logic        [plk_pkg::COEF_W-1:0]   loss,
    input logic signed [plk_pkg::COEF_W-1:0]   tune
  );
    int unsigned gap;
    gap = feed_steady ? 0 : idle_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_pluck_sample  <= pluck;
    in_pitch_q4      <= pitch;
    in_stretch_coeff <= stretch;
    in_loss_coeff    <= loss;
    in_tune_coeff    <= tune;
    do @(posedge clk); while (in_stall);
  endtask

  // The rate is only changed once every outstanding word has come back.
  task automatic write_sample_rate(input logic [plk_pkg::RATE_W-1:0] rate);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
    cfg_valid       <= 1'b1;
    cfg_sample_rate <= rate;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Full-scale plucks into a one-slot loop, coefficients at and above one, sub-Hz pitches.
  task automatic test_loop_extremes();
    send_sample(PEAK_POS, PITCH_TOP, COEF_UNIT, COEF_UNIT, 16'sd0);
    send_sample(PEAK_POS, PITCH_TOP, COEF_UNIT, COEF_UNIT, 16'sd0);
    send_sample(PEAK_NEG, PITCH_TOP, COEF_TOP, COEF_TOP, PEAK_POS);
    send_sample(PEAK_NEG, PITCH_TOP, 16'd0, COEF_TOP, PEAK_NEG);
    send_sample(PEAK_NEG, PITCH_TOP, 16'd0, 16'd0, PEAK_NEG);
    send_sample(16'sd0, 20'd0, 16'd16384, COEF_UNIT, PEAK_POS);
    send_sample(16'sd1234, 20'd15, COEF_UNIT, COEF_UNIT, PEAK_NEG);
    send_sample(-16'sd1234, plk_pkg::PITCH_MIN, 16'd0, 16'd0, 16'sd0);
  endtask

  // Shrinking the loop below the current position, then growing it by one slot.
  task automatic test_position_wrap();
    send_sample(16'sd20000, 20'd384000, COEF_UNIT, COEF_UNIT, 16'sd0);
    send_sample(-16'sd20000, 20'd384000, COEF_UNIT, COEF_UNIT, 16'sd0);
    send_sample(16'sd0, 20'd384000, 16'd16384, 16'd32000, 16'sd12000);
    send_sample(16'sd0, 20'd384000, 16'd16384, 16'd32000, -16'sd12000);
    send_sample(16'sd100, 20'd384000, 16'd8000, 16'd0, PEAK_POS);
    send_sample(16'sd0, 20'd384000, COEF_UNIT, COEF_UNIT, PEAK_NEG);
    send_sample(16'sd5000, 20'd256000, COEF_UNIT, COEF_UNIT, 16'sd3000);
    send_sample(16'sd0, 20'd256000, 16'd20000, 16'd32700, 16'sd3000);
    send_sample(16'sd0, 20'd256000, 16'd20000, 16'd32700, 16'sd3000);
  endtask

  // A zero rate forces a one-slot loop; the top rate overflows the delay memory.
  task automatic test_rate_extremes();
    write_sample_rate('0);
    send_sample(16'sd7000, plk_pkg::PITCH_MIN, COEF_UNIT, COEF_UNIT, 16'sd0);
    send_sample(16'sd0, PITCH_TOP, COEF_UNIT, COEF_UNIT, 16'sd500);
    write_sample_rate(RATE_TOP);
    send_sample(-16'sd7000, plk_pkg::PITCH_MIN, COEF_UNIT, COEF_UNIT, 16'sd0);
    send_sample(16'sd0, 20'd0, 16'd30000, COEF_UNIT, -16'sd500);
    send_sample(16'sd0, 20'd64, 16'd30000, COEF_UNIT, 16'sd0);
  endtask

  // Notes of one period of noise then ringing, random coefficients; also lone random words.
  task automatic test_random_notes(input int unsigned item_count);
    int unsigned                         sent;
    int unsigned                         period;
    int unsigned                         note_len;
    int unsigned                         k;
    int unsigned                         choice;
    longint                              pitch_calc;
    logic        [plk_pkg::PITCH_W-1:0]  pitch;
    logic        [plk_pkg::COEF_W-1:0]   stretch;
    logic        [plk_pkg::COEF_W-1:0]   loss;
    logic signed [plk_pkg::COEF_W-1:0]   tune;
    logic signed [plk_pkg::SAMPLE_W-1:0] pluck;
    sent = 0;
    while (sent < item_count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample(16'($urandom), 20'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end else begin
        choice = $urandom_range(0, 99);
        if (choice < 70) begin
          period = $urandom_range(2, 40);
        end else if (choice < 92) begin
          period = $urandom_range(41, 300);
        end else begin
          period = $urandom_range(301, 2000);
        end
        pitch_calc = (longint'(rate_hz) * 16) / period + $urandom_range(0, 7);
        if (pitch_calc > longint'(PITCH_TOP)) begin
          pitch_calc = longint'(PITCH_TOP);
        end
        pitch = plk_pkg::PITCH_W'(pitch_calc);
        stretch = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(32769, 65535))
                                              : 16'($urandom_range(8192, 32768));
        loss = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(30000, 32768));
        tune = 16'($urandom);
        note_len = $urandom_range(period, 3 * period + 24);
        for (k = 0; k < note_len && sent < item_count; k++) begin
          if (k < period) begin
            pluck = 16'($urandom);
          end else if ($urandom_range(0, 3) == 0) begin
            pluck = 16'($urandom_range(0, 511)) - 16'sd256;
          end else begin
            pluck = '0;
          end
          send_sample(pluck, pitch, stretch, loss, tune);
          sent++;
        end
      end
    end
  endtask

  initial begin
    reset_string_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_loop_extremes();
    test_position_wrap();
    test_rate_extremes();

    write_sample_rate(plk_pkg::RATE_RESET);
    test_random_notes(370);
    write_sample_rate(18'd44100);
    test_random_notes(370);
    // A stretch with neither side holding back.
    write_sample_rate(18'd1000);
    feed_steady = 1'b1;
    sink_steady = 1'b1;
    test_random_notes(360);
    feed_steady = 1'b0;
    sink_steady = 1'b0;
    write_sample_rate(18'd192000);
    test_random_notes(370);
    write_sample_rate(plk_pkg::RATE_W'($urandom_range(1000, 192000)));
    test_random_notes(360);

    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_samples.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
